// ===== sv/prd_pkg.sv =====
// Package for the capture-file deframer: transaction types, phase and kind codes,
// header constants and the byte-swap helper. No dependencies.
package prd_pkg;

  localparam int unsigned HDR_COUNT_W = 5;

  localparam logic [31:0] MAGIC_WORD = 32'ha1b2c3d4;
  localparam logic [31:0] VERSION_BE = 32'h00020004;
  localparam logic [31:0] VERSION_LE = 32'h02000400;

  // Byte positions inside the headers
  localparam logic [HDR_COUNT_W-1:0] MAGIC_LAST   = 5'd3;
  localparam logic [HDR_COUNT_W-1:0] VERSION_LAST = 5'd7;
  localparam logic [HDR_COUNT_W-1:0] GLOBAL_LAST  = 5'd23;
  localparam logic [HDR_COUNT_W-1:0] RECORD_LAST  = 5'd15;
  localparam logic [HDR_COUNT_W-1:0] LEN_FIRST    = 5'd8;
  localparam logic [HDR_COUNT_W-1:0] LEN_LAST     = 5'd11;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_BAD_MAGIC = 3'd2,
    KIND_VERSION   = 3'd3,
    KIND_TRUNC     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        packet_first;
    logic        packet_last;
    logic [31:0] incl_len;
    logic        truncated;
  } out_item_t;

  typedef struct packed {
    phase_t phase;
    logic   bytes_left_zero;
  } prd_status_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ===== sv/pcap_record_deframer.sv =====
// Top level of the capture-file deframer: input register, step logic, result
// register. Uses prd_pkg and prd_parser.
//
// Usage:
//   byte channel   (byte_valid / byte_stall / byte_item): one file byte per
//                  transaction, file_end set on the last byte of the file.
//   result channel (result_valid / result_stall / result_item): zero or one
//                  result per byte: payload bytes with first/last marks and the
//                  record length, empty-packet, bad-magic, version-warning and
//                  truncated-file results.
// Throughput: one byte per cycle while the result channel does not stall; the
// state update for a byte is a single pass from the input register through the
// parser into the result register. A result is offered once its byte has left
// the input register; a result stall can hold the byte there.
// Bytes that give no result still take their slot in the pipe.
// Reset clears both valid flags and the parser, which then expects a global header.
// After a byte with file_end the parser returns to that same start state.
// A stalled result holds; the input register then fills and byte_stall rises,
// so no transaction is lost while the receiver stalls.
module pcap_record_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  prd_pkg::in_item_t  byte_item,
  output logic               result_valid,
  input  logic               result_stall,
  output prd_pkg::out_item_t result_item
);

  logic                  in_q_valid;
  prd_pkg::in_item_t     in_q;
  logic                  advance;
  logic                  res_valid;
  prd_pkg::out_item_t    res;
  prd_pkg::prd_status_t  status;

  assign advance    = in_q_valid && (!result_valid || !result_stall);
  assign byte_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_q_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      in_q <= byte_item;
    end
  end

  prd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (in_q),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_inreg_hold: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid && $stable(in_q))
    else $error("input register lost a held byte");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    status.phase == prd_pkg::PH_PAYLOAD |-> !status.bytes_left_zero)
    else $error("payload phase with no bytes left");

  a_empty_packet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.kind == prd_pkg::KIND_EMPTY |->
      result_item.packet_last && !result_item.packet_first &&
      result_item.incl_len == 32'd0)
    else $error("malformed empty-packet result");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.file_end |=> status.phase == prd_pkg::PH_GLOBAL)
    else $error("parser did not restart after file end");
`endif

endmodule

// ===== sv/prd_parser.sv =====
// Deframer state and per-byte step logic: header parsing, payload marking and
// file-end handling. Uses prd_pkg.
module prd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  prd_pkg::in_item_t   item,
  output logic                res_valid,
  output prd_pkg::out_item_t  res,
  output prd_pkg::prd_status_t status
);

  localparam logic [prd_pkg::HDR_COUNT_W-1:0] COUNT_STEP =
    {{(prd_pkg::HDR_COUNT_W-1){1'b0}}, 1'b1};

  prd_pkg::phase_t                   phase, phase_next;
  logic [prd_pkg::HDR_COUNT_W-1:0]   header_count, header_count_next;
  logic                              big_endian, big_endian_next;
  logic [31:0]                       header_shift, header_shift_next;
  logic [31:0]                       record_length, record_length_next;
  logic [31:0]                       bytes_left, bytes_left_next;

  logic [31:0] shifted;
  logic [31:0] left_dec;
  logic        done;
  logic        n;

  assign shifted  = {header_shift[23:0], item.file_byte};
  assign left_dec = bytes_left - 32'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    big_endian_next    = big_endian;
    header_shift_next  = header_shift;
    record_length_next = record_length;
    bytes_left_next    = bytes_left;
    done               = 1'b0;
    n                  = 1'b0;
    res                = '0;
    res.kind           = prd_pkg::KIND_PAYLOAD;

    unique case (phase)
      prd_pkg::PH_GLOBAL: begin
        if (header_count < prd_pkg::LEN_FIRST) begin
          header_shift_next = shifted;
        end
        if (header_count == prd_pkg::MAGIC_LAST) begin
          header_shift_next = '0;
          if (prd_pkg::swap_bytes(shifted) == prd_pkg::MAGIC_WORD) begin
            big_endian_next = 1'b0;
          end else if (shifted == prd_pkg::MAGIC_WORD) begin
            big_endian_next = 1'b1;
          end else begin
            res.kind   = prd_pkg::KIND_BAD_MAGIC;
            n          = 1'b1;
            phase_next = prd_pkg::PH_ERROR;
          end
        end else if (header_count == prd_pkg::VERSION_LAST) begin
          header_shift_next = '0;
          if (big_endian ? (shifted != prd_pkg::VERSION_BE)
                         : (shifted != prd_pkg::VERSION_LE)) begin
            res.kind = prd_pkg::KIND_VERSION;
            n        = 1'b1;
          end
        end
        if (phase_next == prd_pkg::PH_GLOBAL) begin
          if (header_count == prd_pkg::GLOBAL_LAST) begin
            phase_next        = prd_pkg::PH_RECORD;
            header_count_next = '0;
            done              = 1'b1;
          end else begin
            header_count_next = header_count + COUNT_STEP;
          end
        end
      end
      prd_pkg::PH_RECORD: begin
        if (header_count >= prd_pkg::LEN_FIRST && header_count <= prd_pkg::LEN_LAST) begin
          header_shift_next = shifted;
        end
        if (header_count == prd_pkg::RECORD_LAST) begin
          // length bytes are all in header_shift by now; this byte is not one
          record_length_next = big_endian ? header_shift
                                          : prd_pkg::swap_bytes(header_shift);
          header_shift_next  = '0;
          header_count_next  = '0;
          if (record_length_next == '0) begin
            res.kind        = prd_pkg::KIND_EMPTY;
            res.packet_last = 1'b1;
            n               = 1'b1;
            done            = 1'b1;
          end else begin
            bytes_left_next = record_length_next;
            phase_next      = prd_pkg::PH_PAYLOAD;
          end
        end else begin
          header_count_next = header_count + COUNT_STEP;
        end
      end
      prd_pkg::PH_PAYLOAD: begin
        res.kind          = prd_pkg::KIND_PAYLOAD;
        res.data_byte     = item.file_byte;
        res.packet_first  = (bytes_left == record_length);
        res.packet_last   = (bytes_left == 32'd1);
        res.incl_len      = record_length;
        n                 = 1'b1;
        bytes_left_next   = left_dec;
        if (left_dec == '0) begin
          phase_next = prd_pkg::PH_RECORD;
          done       = 1'b1;
        end
      end
      prd_pkg::PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (item.file_end) begin
      if (n) begin
        res.truncated = !done;
      end else if (!done && phase != prd_pkg::PH_ERROR) begin
        res           = '0;
        res.kind      = prd_pkg::KIND_TRUNC;
        res.truncated = 1'b1;
        n             = 1'b1;
      end
      phase_next         = prd_pkg::PH_GLOBAL;
      header_count_next  = '0;
      big_endian_next    = 1'b0;
      header_shift_next  = '0;
      record_length_next = '0;
      bytes_left_next    = '0;
    end
  end

  assign res_valid = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= prd_pkg::PH_GLOBAL;
      header_count  <= '0;
      big_endian    <= 1'b0;
      header_shift  <= '0;
      record_length <= '0;
      bytes_left    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      big_endian    <= big_endian_next;
      header_shift  <= header_shift_next;
      record_length <= record_length_next;
      bytes_left    <= bytes_left_next;
    end
  end

  assign status.phase           = phase;
  assign status.bytes_left_zero = (bytes_left == '0);

endmodule
